/* hw/rtl/lrukv_pkg.sv */
// shared constants and types for the lru key-value table
`timescale 1ns / 1ps
package lrukv_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 64;
    localparam int RANK_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int DL_BITS     = 41;

    typedef enum logic [2:0] {
        KIND_SET     = 3'd0,
        KIND_SET_TTL = 3'd1,
        KIND_GET     = 3'd2,
        KIND_DEL     = 3'd3,
        KIND_QUERY   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_NO_EXPIRY = 2'd2,
        ST_EXPIRY    = 2'd3
    } status_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic                 drop_rank;  // drop the entry holding rank ref_rank
        logic                 touch;      // cell holding ref_rank becomes newest
        logic                 write;      // cell with write_sel set stores payload
        logic                 insert;     // write is a fresh key
        logic [RANK_BITS-1:0] ref_rank;
        logic [RANK_BITS-1:0] new_rank;
        logic [TABLE_DEPTH-1:0] write_sel;
        logic                 expires;
        logic [DL_BITS-1:0]   deadline;
        logic [KEY_BITS-1:0]  key;
        logic [VALUE_BITS-1:0] value;
    } cell_cmd_t;

    // status a cell reports back
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic                  expires;
        logic [RANK_BITS-1:0]  rank;
        logic [DL_BITS-1:0]    deadline;
        logic [VALUE_BITS-1:0] value;
    } cell_stat_t;
endpackage

/* hw/rtl/lrukv_req_if.sv */
// request and result channel interfaces
`timescale 1ns / 1ps
interface lrukv_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] key;
    logic [63:0] value;
    logic [31:0] ttl_seconds;
    logic [39:0] now_seconds;
    modport source (output valid, kind, key, value, ttl_seconds, now_seconds, input ready);
    modport sink (input valid, kind, key, value, ttl_seconds, now_seconds, output ready);
endinterface

interface lrukv_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [31:0] remaining_seconds;
    modport source (output valid, status, read_value, remaining_seconds, input ready);
    modport sink (input valid, status, read_value, remaining_seconds, output ready);
endinterface

/* hw/rtl/lru_ttl_key_value_table.sv */
// lru key-value table with per-key expiry, built from a row of slot cells
// A get, delete, query or unused kind goes from acceptance to a valid result through the
// request registers, the key compare in every cell (S_MATCH), the decision (S_DECIDE) and
// the output register load (S_OUT). A set of a present key passes through S_TRIM, which
// drops the keys trimmed after max_entries was lowered. A set of a new key goes through
// S_EVICT, which evicts least recently used keys until below the limit, then S_WRITE and S_TRIM.
// The block takes one request at a time and takes no new one while a result waits
// unaccepted in the output register; max_entries is written by cfg_we/cfg_data.
`timescale 1ns / 1ps
module lru_ttl_key_value_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [4:0]       cfg_data,
    lrukv_req_if.sink        req,
    lrukv_rsp_if.source      rsp
);
    import lrukv_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MATCH  = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_EVICT  = 7'b0001000,
        S_WRITE  = 7'b0010000,
        S_TRIM   = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [4:0]            max_reg;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    kind_t                 kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [31:0]           ttl_reg;
    logic [39:0]           now_reg;
    logic [TABLE_DEPTH-1:0] hit_reg;
    logic [TABLE_DEPTH-1:0] free_sel;
    logic                  found;
    logic [RANK_BITS-1:0]  hit_rank;
    logic                  hit_exp;
    logic [DL_BITS-1:0]    hit_dl;
    logic [VALUE_BITS-1:0] hit_val;
    logic [CNT_BITS-1:0]   lim;
    logic [1:0]            status_reg, status_next;
    logic [63:0]           rd_reg, rd_next;
    logic [31:0]           rem_reg, rem_next;
    logic                  out_valid_reg;
    cell_cmd_t             cmd;
    cell_stat_t            stat [TABLE_DEPTH];
    logic [DL_BITS-1:0]    now_ext;
    logic                  expired;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            lrukv_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .self_sel  (cmd.write_sel[g]),
                .match_key (key_reg),
                .cmd       (cmd),
                .stat      (stat[g])
            );
        end
    endgenerate

    // limit clamped to 1..TABLE_DEPTH
    always_comb
    begin
        if (max_reg == '0)
            lim = CNT_BITS'(1);
        else if (32'(max_reg) > TABLE_DEPTH)
            lim = CNT_BITS'(TABLE_DEPTH);
        else
            lim = CNT_BITS'(max_reg);
    end

    // registered hit vector is one-hot at most; or-reduce the hit cell fields
    always_comb
    begin
        found    = |hit_reg;
        hit_rank = '0;
        hit_exp  = 1'b0;
        hit_dl   = '0;
        hit_val  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (hit_reg[i])
            begin
                hit_rank = hit_rank | stat[i].rank;
                hit_exp  = hit_exp | stat[i].expires;
                hit_dl   = hit_dl | stat[i].deadline;
                hit_val  = hit_val | stat[i].value;
            end
        end
    end

    // lowest free slot
    always_comb
    begin
        free_sel = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!stat[i].valid)
                free_sel = TABLE_DEPTH'(1) << i;
        end
    end

    assign now_ext = {1'b0, now_reg};
    assign expired = hit_exp && (now_ext >= hit_dl);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd            = '0;
        cmd.key        = key_reg;
        cmd.value      = value_reg;
        cmd.expires    = (kind_reg == KIND_SET_TTL);
        cmd.deadline   = (kind_reg == KIND_SET_TTL) ?
                         (now_ext + DL_BITS'(ttl_reg)) : '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                    state_next = S_MATCH;
            end
            S_MATCH:
                state_next = S_DECIDE;
            S_DECIDE:
            begin
                state_next = S_OUT;
                case (kind_reg)
                    KIND_SET, KIND_SET_TTL:
                    begin
                        if (found)
                        begin
                            cmd.touch     = 1'b1;
                            cmd.ref_rank  = hit_rank;
                            cmd.new_rank  = RANK_BITS'(count_reg - 1'b1);
                            cmd.write     = 1'b1;
                            cmd.write_sel = hit_reg;
                            state_next    = S_TRIM;
                        end
                        else
                            state_next = S_EVICT;
                    end
                    KIND_GET:
                    begin
                        if (found)
                        begin
                            cmd.ref_rank = hit_rank;
                            if (expired)
                            begin
                                cmd.drop_rank = 1'b1;
                                count_next    = count_reg - 1'b1;
                            end
                            else
                            begin
                                cmd.touch    = 1'b1;
                                cmd.new_rank = RANK_BITS'(count_reg - 1'b1);
                            end
                        end
                    end
                    KIND_DEL:
                    begin
                        if (found)
                        begin
                            cmd.ref_rank  = hit_rank;
                            cmd.drop_rank = 1'b1;
                            count_next    = count_reg - 1'b1;
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (found && expired)
                        begin
                            cmd.ref_rank  = hit_rank;
                            cmd.drop_rank = 1'b1;
                            count_next    = count_reg - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_EVICT:
            begin
                // make room for a new key, one victim per cycle
                if (count_reg >= lim)
                begin
                    cmd.drop_rank = 1'b1;
                    cmd.ref_rank  = '0;
                    count_next    = count_reg - 1'b1;
                end
                else
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write     = 1'b1;
                cmd.insert    = 1'b1;
                cmd.write_sel = free_sel;
                cmd.new_rank  = RANK_BITS'(count_reg);
                count_next    = count_reg + 1'b1;
                state_next    = S_TRIM;
            end
            S_TRIM:
            begin
                if (count_reg > lim)
                begin
                    cmd.drop_rank = 1'b1;
                    cmd.ref_rank  = '0;
                    count_next    = count_reg - 1'b1;
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // result fields decided from the hit cell
    always_comb
    begin
        status_next = ST_ABSENT;
        rd_next     = '0;
        rem_next    = '0;
        case (kind_reg)
            KIND_SET, KIND_SET_TTL:
                status_next = ST_OK;
            KIND_GET:
            begin
                if (found && !expired)
                begin
                    status_next = ST_OK;
                    rd_next     = hit_val;
                end
            end
            KIND_DEL:
            begin
                if (found)
                    status_next = ST_OK;
            end
            KIND_QUERY:
            begin
                if (found && !hit_exp)
                    status_next = ST_NO_EXPIRY;
                else if (found && !expired)
                begin
                    status_next = ST_EXPIRY;
                    rem_next    = 32'(hit_dl - now_ext);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            max_reg       <= 5'd16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
                max_reg <= cfg_data;
            if (state_reg == S_OUT && (!out_valid_reg || rsp.ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            kind_reg  <= kind_t'(req.kind);
            key_reg   <= req.key;
            value_reg <= req.value;
            ttl_reg   <= req.ttl_seconds;
            now_reg   <= req.now_seconds;
        end
        if (state_reg == S_MATCH)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                hit_reg[i] <= stat[i].hit;
        end
        if (state_reg == S_DECIDE)
        begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
            rem_reg    <= rem_next;
        end
    end

    // a new item is taken only once the output register is free at this edge
    assign req.ready             = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = status_reg;
    assign rsp.read_value        = rd_reg;
    assign rsp.remaining_seconds = rem_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE |-> $onehot0(hit_reg))
        else $error("key present in more than one slot");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req.ready)
        else $error("request taken while busy");
endmodule

/* hw/rtl/lrukv_cell.sv */
// one table slot: key, value, expiry and recency rank
`timescale 1ns / 1ps
module lrukv_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  self_sel,
    input  logic [lrukv_pkg::KEY_BITS-1:0] match_key,
    input  lrukv_pkg::cell_cmd_t  cmd,
    output lrukv_pkg::cell_stat_t stat
);
    import lrukv_pkg::*;

    logic                  valid_reg;
    logic                  expires_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [DL_BITS-1:0]    deadline_reg;
    logic [RANK_BITS-1:0]  rank_reg;
    logic                  is_ref;
    logic                  above_ref;

    assign is_ref    = valid_reg && (rank_reg == cmd.ref_rank);
    assign above_ref = valid_reg && (rank_reg > cmd.ref_rank);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            expires_reg <= 1'b0;
        end
        else if (cmd.write && self_sel)
        begin
            valid_reg   <= 1'b1;
            expires_reg <= cmd.expires;
        end
        else if (cmd.drop_rank && is_ref)
        begin
            valid_reg   <= 1'b0;
            expires_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && self_sel)
        begin
            value_reg    <= cmd.value;
            deadline_reg <= cmd.deadline;
            if (cmd.insert)
            begin
                key_reg  <= cmd.key;
                rank_reg <= cmd.new_rank;
            end
        end
        if ((cmd.drop_rank || cmd.touch) && above_ref)
            rank_reg <= rank_reg - 1'b1;
        else if (cmd.touch && is_ref)
            rank_reg <= cmd.new_rank;
    end

    assign stat.valid    = valid_reg;
    assign stat.hit      = valid_reg && (key_reg == match_key);
    assign stat.expires  = expires_reg;
    assign stat.rank     = rank_reg;
    assign stat.deadline = deadline_reg;
    assign stat.value    = value_reg;
endmodule

/* tb/tb_top.sv */
// self-checking testbench for the lru key-value table with per-key expiry
`timescale 1ns / 1ps
module tb_top;
    import lrukv_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [4:0] cfg_data = 5'd0;
    int unsigned cycle_count = 0;
    bit idle_enabled = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 400000;

    lrukv_req_if req ();
    lrukv_rsp_if rsp ();

    lru_ttl_key_value_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req),
        .rsp      (rsp)
    );

    always #5 clk = ~clk;

    typedef struct {
        status_t     status;
        logic [63:0] read_value;
        logic [31:0] remaining;
    } result_t;

    class table_scoreboard;
        int unsigned limit_reg;
        bit          live[TABLE_DEPTH];
        logic [63:0] key_of[TABLE_DEPTH];
        logic [63:0] val_of[TABLE_DEPTH];
        bit          ttl_on[TABLE_DEPTH];
        logic [40:0] deadline[TABLE_DEPTH];
        int unsigned rank[TABLE_DEPTH];
        int unsigned count;
        result_t     pending[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            limit_reg = 16;
            count = 0;
            errors = 0;
            checked = 0;
            foreach (live[i])
            begin
                live[i] = 1'b0;
                ttl_on[i] = 1'b0;
                rank[i] = 0;
            end
        endfunction

        function int lookup(logic [63:0] k);
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (live[i] && key_of[i] == k)
                    return i;
            return -1;
        endfunction

        function void remove(int s);
            int unsigned r;
            r = rank[s];
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (live[i] && rank[i] > r)
                    rank[i]--;
            live[s] = 1'b0;
            ttl_on[s] = 1'b0;
            if (count > 0)
                count--;
        endfunction

        function void promote(int s);
            int unsigned r;
            r = rank[s];
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (live[i] && rank[i] > r)
                    rank[i]--;
            rank[s] = count - 1;
        endfunction

        function int unsigned cap();
            if (limit_reg == 0)
                return 1;
            if (limit_reg > TABLE_DEPTH)
                return TABLE_DEPTH;
            return limit_reg;
        endfunction

        function void shrink_to(int unsigned c);
            int victim;
            while (count > c)
            begin
                victim = -1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (live[i] && rank[i] == 0)
                    begin
                        victim = i;
                        break;
                    end
                if (victim < 0)
                    return;
                remove(victim);
            end
        endfunction

        function void note_request(logic [2:0] kind, logic [63:0] k, logic [63:0] v,
                                   logic [31:0] ttl, logic [39:0] now);
            result_t res;
            int s;
            logic [40:0] t_now;
            t_now = {1'b0, now};
            res.status = ST_ABSENT;
            res.read_value = '0;
            res.remaining = '0;
            s = lookup(k);
            if (kind == KIND_SET || kind == KIND_SET_TTL)
            begin
                if (s < 0)
                begin
                    shrink_to(cap() - 1);
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (!live[i])
                        begin
                            s = i;
                            break;
                        end
                    if (s >= 0)
                    begin
                        live[s] = 1'b1;
                        key_of[s] = k;
                        rank[s] = count;
                        count++;
                    end
                end
                else
                    promote(s);
                if (s >= 0)
                begin
                    val_of[s] = v;
                    ttl_on[s] = (kind == KIND_SET_TTL);
                    deadline[s] = (kind == KIND_SET_TTL) ? t_now + {9'd0, ttl} : '0;
                end
                shrink_to(cap());
                res.status = ST_OK;
            end
            else if (kind == KIND_GET)
            begin
                if (s >= 0)
                begin
                    if (ttl_on[s] && t_now >= deadline[s])
                        remove(s);
                    else
                    begin
                        promote(s);
                        res.read_value = val_of[s];
                        res.status = ST_OK;
                    end
                end
            end
            else if (kind == KIND_DEL)
            begin
                if (s >= 0)
                begin
                    remove(s);
                    res.status = ST_OK;
                end
            end
            else if (kind == KIND_QUERY)
            begin
                if (s >= 0)
                begin
                    if (!ttl_on[s])
                        res.status = ST_NO_EXPIRY;
                    else if (t_now >= deadline[s])
                        remove(s);
                    else
                    begin
                        res.status = ST_EXPIRY;
                        res.remaining = 32'(deadline[s] - t_now);
                    end
                end
            end
            pending = {pending, res};
        endfunction

        function void check_result(logic [1:0] st, logic [63:0] rv, logic [31:0] rem);
            result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, st);
                errors++;
            end
            if (rv !== e.read_value)
            begin
                $error("read_value expected %h actual %h", e.read_value, rv);
                errors++;
            end
            if (rem !== e.remaining)
            begin
                $error("remaining_seconds expected %0d actual %0d", e.remaining, rem);
                errors++;
            end
        endfunction
    endclass

    table_scoreboard sb = new();

    // key pool kept small so hits, evictions and expiries happen often
    logic [63:0] key_pool[8];
    logic [39:0] clock_now = 40'd1000;
    int unsigned sent = 0;

    initial
    begin
        req.valid = 1'b0;
        req.kind = '0;
        req.key = '0;
        req.value = '0;
        req.ttl_seconds = '0;
        req.now_seconds = '0;
        rsp.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.kind, req.key, req.value, req.ttl_seconds, req.now_seconds);
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result(rsp.status, rsp.read_value, rsp.remaining_seconds);
    end

    // result side: random stall bursts
    initial
    begin
        int unsigned burst;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_enabled && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                burst = $urandom_range(1, 13);
                repeat (burst) @(negedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    // valid stays high into the next call; drain lowers it
    task automatic send_request(logic [2:0] kind, logic [63:0] k, logic [63:0] v,
                                logic [31:0] ttl, logic [39:0] now);
        if (idle_enabled && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= kind;
        req.key <= k;
        req.value <= v;
        req.ttl_seconds <= ttl;
        req.now_seconds <= now;
        do @(posedge clk); while (!(req.valid && req.ready));
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic set_limit(logic [4:0] m);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.limit_reg = m;
    endtask

    task automatic random_request();
        logic [2:0] kind;
        logic [63:0] k;
        logic [31:0] ttl;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            kind = KIND_SET;
        else if (pick < 45)
            kind = KIND_SET_TTL;
        else if (pick < 70)
            kind = KIND_GET;
        else if (pick < 80)
            kind = KIND_DEL;
        else if (pick < 97)
            kind = KIND_QUERY;
        else
            kind = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) == 0)
            k = {$urandom, $urandom};
        else
            k = key_pool[$urandom_range(0, 7)];
        case ($urandom_range(0, 9))
            0: ttl = 32'd0;
            1: ttl = $urandom;
            default: ttl = 32'($urandom_range(1, 20));
        endcase
        // time mostly creeps forward, sometimes jumps
        if ($urandom_range(0, 19) == 0)
            clock_now = 40'({$urandom, $urandom});
        else
            clock_now = clock_now + 40'($urandom_range(0, 3));
        send_request(kind, k, {$urandom, $urandom}, ttl, clock_now);
    endtask

    initial
    begin
        logic [63:0] ones;
        logic [39:0] tmax;
        ones = '1;
        tmax = '1;
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = ones;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, each kind, expiry edges, unused kinds
        send_request(KIND_SET, '0, ones, '0, '0);
        send_request(KIND_GET, '0, '0, '0, '0);
        send_request(KIND_QUERY, '0, '0, '0, '0);
        send_request(KIND_SET_TTL, ones, 64'h5555_5555_5555_5555, '1, tmax);
        send_request(KIND_QUERY, ones, '0, '0, tmax);
        send_request(KIND_GET, ones, '0, '0, tmax - 40'd1);
        send_request(KIND_SET_TTL, 64'd7, 64'd1, 32'd0, 40'd50);
        send_request(KIND_GET, 64'd7, '0, '0, 40'd50);
        send_request(KIND_SET_TTL, 64'd8, 64'd2, 32'd10, 40'd50);
        send_request(KIND_QUERY, 64'd8, '0, '0, 40'd59);
        send_request(KIND_QUERY, 64'd8, '0, '0, 40'd60);
        send_request(KIND_GET, 64'd8, '0, '0, 40'd61);
        send_request(KIND_SET_TTL, 64'd9, 64'd3, 32'd5, 40'd10);
        send_request(KIND_SET, 64'd9, 64'd4, 32'd5, 40'd100);
        send_request(KIND_QUERY, 64'd9, '0, '0, 40'd100);
        send_request(KIND_DEL, 64'd9, '0, '0, '0);
        send_request(KIND_DEL, 64'd9, '0, '0, '0);
        send_request(3'd5, ones, ones, '1, tmax);
        send_request(3'd6, '0, '0, '0, '0);
        send_request(3'd7, '0, '0, '0, '0);

        // full table, then a lowered limit forces eviction of older keys
        for (int i = 0; i < 17; i++)
            send_request(KIND_SET, 64'(100 + i), 64'(i), '0, '0);
        set_limit(5'd3);
        send_request(KIND_SET, 64'd116, 64'd9, '0, '0);
        send_request(KIND_GET, 64'd101, '0, '0, '0);

        // the sender waits for everything before continuing
        drain();

        begin
            logic [4:0] limits[6];
            limits = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd4, 5'd7};
            foreach (limits[p])
            begin
                set_limit(limits[p]);
                repeat (250) random_request();
            end
        end
        idle_enabled = 1'b0;
        repeat (250) random_request();

        drain();
        $display("%0d requests sent, %0d results checked over limits 0 to 31",
                 sent, sb.checked);
        $display("covered set, expiring set, get, delete, query, expiry and eviction");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
